@@ design/gregorian_date_add_days_unit_defines.svh @@
// Assertion macros shared by the date adder RTL.
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GDAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gdad_pkg.sv @@
// Package with widths, calendar constants, types and helpers of the date adder.
`default_nettype none

package gdad_pkg;

    localparam int unsigned DAY_W          = 5;
    localparam int unsigned MON_W          = 4;
    localparam int unsigned YEAR_W         = 14;
    localparam int unsigned YMOD_W         = 9;
    localparam int unsigned DAYS_WIDTH_DEF = 20;

    localparam int unsigned CYCLE_DAYS  = 146097;
    localparam int unsigned CYCLE_YEARS = 400;
    localparam int unsigned CENTURY     = 100;
    localparam int unsigned LEAP_FEB    = 29;

    // Largest shift of the cycle length in years that still fits a year value.
    localparam int unsigned MOD_SHIFT_MAX = 5;
    localparam int unsigned STEP_W        = 3;

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
    };

    typedef struct packed {
        logic borrow;
        logic zero;
    } t_alu_flags;

    // Leap rule applied to the year modulo 400.
    function automatic logic leap_of(input logic [YMOD_W-1:0] ymod);
        logic century;
        century = (ymod == YMOD_W'(CENTURY)) || (ymod == YMOD_W'(2 * CENTURY)) ||
                  (ymod == YMOD_W'(3 * CENTURY));
        leap_of = (ymod[1:0] == 2'b00) && !century;
    endfunction

    // Month length; codes outside January to December have length zero.
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [MON_W-1:0] idx;
        idx = m - MON_W'(1);
        case (m) inside
            MON_FEB:           month_days = leap ? DAY_W'(LEAP_FEB) : MONTH_LEN[idx];
            [MON_JAN:MON_DEC]: month_days = MONTH_LEN[idx];
            default:           month_days = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ design/gdad_if.sv @@
// Valid/ready channel interfaces carrying the start date and the end date.
`default_nettype none

interface gdad_in_if #(
    parameter int unsigned DAYS_WIDTH = gdad_pkg::DAYS_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [gdad_pkg::DAY_W-1:0]    start_day;
    logic [gdad_pkg::MON_W-1:0]    start_month;
    logic [gdad_pkg::YEAR_W-1:0]   start_year;
    logic [DAYS_WIDTH-1:0]         days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface gdad_out_if;
    logic                          valid;
    logic                          ready;
    logic [gdad_pkg::DAY_W-1:0]    end_day;
    logic [gdad_pkg::MON_W-1:0]    end_month;
    logic [gdad_pkg::YEAR_W-1:0]   end_year;

    modport source (output valid, end_day, end_month, end_year, input ready);
    modport sink   (input valid, end_day, end_month, end_year, output ready);
endinterface

`default_nettype wire

@@ design/gregorian_date_add_days_unit.sv @@
// Run time per transaction grows with the start month, the number of whole 400-year cycles
// skipped and the number of months walked, and with any wait for the output register.
// Throughput: one transaction at a time; the month walk through the shared adder sets the rate.
// The input is ready only while idle; the result waits in an output register, so a new
// transaction may start while the previous result has not yet been taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops the result valid.
`default_nettype none

`include "gregorian_date_add_days_unit_defines.svh"

module gregorian_date_add_days_unit #(
    parameter int unsigned DAYS_WIDTH = gdad_pkg::DAYS_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gdad_in_if.sink     i_in,
    gdad_out_if.source  o_out
);

    // The running total must hold the day count plus one year of ordinal days, and must
    // also be wide enough to compare against the length of a 400-year cycle.
    localparam int unsigned TW = (DAYS_WIDTH + 2 > 18) ? DAYS_WIDTH + 2 : 18;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_DAY,
        S_PRE,
        S_CYC,
        S_WALK
    } t_state;

    t_state                           r_state, n_state;
    logic [TW-1:0]                    r_total, n_total;
    logic [gdad_pkg::YEAR_W-1:0]      r_year, n_year;
    // Year modulo 400; during the reduction phase it holds the partial remainder.
    logic [gdad_pkg::YEAR_W-1:0]      r_yrem, n_yrem;
    logic [gdad_pkg::MON_W-1:0]       r_m, n_m;
    logic [gdad_pkg::MON_W-1:0]       r_mon, n_mon;
    logic [gdad_pkg::DAY_W-1:0]       r_day, n_day;
    logic [gdad_pkg::STEP_W-1:0]      r_step, n_step;
    logic                             r_out_valid, n_out_valid;
    logic [gdad_pkg::DAY_W-1:0]       r_end_day, n_end_day;
    logic [gdad_pkg::MON_W-1:0]       r_end_month, n_end_month;
    logic [gdad_pkg::YEAR_W-1:0]      r_end_year, n_end_year;

    logic [TW-1:0]                    alu_a, alu_b, alu_res;
    logic                             alu_sub;
    gdad_pkg::t_alu_flags             alu_flags;
    logic [gdad_pkg::DAY_W-1:0]       dim;
    logic                             out_free;

    // One adder does the wide arithmetic: the year remainder, the ordinal sum,
    // the cycle skip and the month walk.
    gdad_alu #(.W(TW)) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    assign dim = gdad_pkg::month_days(r_m, gdad_pkg::leap_of(r_yrem[gdad_pkg::YMOD_W-1:0]));

    assign out_free     = !r_out_valid || o_out.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.end_day   = r_end_day;
    assign o_out.end_month = r_end_month;
    assign o_out.end_year  = r_end_year;

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = r_total;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_MOD: begin
                alu_a   = TW'(r_yrem);
                alu_b   = TW'(gdad_pkg::CYCLE_YEARS) << r_step;
                alu_sub = 1'b1;
            end
            S_DAY:  alu_b = TW'(r_day);
            S_PRE:  alu_b = TW'(dim);
            S_CYC: begin
                alu_b   = TW'(gdad_pkg::CYCLE_DAYS);
                alu_sub = 1'b1;
            end
            S_WALK: begin
                alu_b   = TW'(dim);
                alu_sub = 1'b1;
            end
            default: alu_b = '0;
        endcase
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_year      = r_year;
        n_yrem      = r_yrem;
        n_m         = r_m;
        n_mon       = r_mon;
        n_day       = r_day;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_end_day   = r_end_day;
        n_end_month = r_end_month;
        n_end_year  = r_end_year;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_total = TW'(i_in.days_to_add);
                    n_year  = i_in.start_year;
                    n_yrem  = i_in.start_year;
                    n_mon   = i_in.start_month;
                    n_day   = i_in.start_day;
                    n_m     = gdad_pkg::MON_JAN;
                    n_step  = gdad_pkg::STEP_W'(gdad_pkg::MOD_SHIFT_MAX);
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // Restoring reduction of the year by shifted multiples of 400.
                if (!alu_flags.borrow) begin
                    n_yrem = alu_res[gdad_pkg::YEAR_W-1:0];
                end
                if (r_step == '0) begin
                    n_state = S_DAY;
                end else begin
                    n_step = r_step - gdad_pkg::STEP_W'(1);
                end
            end
            S_DAY: begin
                n_total = alu_res;
                n_state = S_PRE;
            end
            S_PRE: begin
                // Add the lengths of all months before the start month.
                if (r_m < r_mon) begin
                    n_total = alu_res;
                    n_m     = r_m + gdad_pkg::MON_W'(1);
                end else begin
                    n_m     = gdad_pkg::MON_JAN;
                    n_state = S_CYC;
                end
            end
            S_CYC: begin
                // Skip whole 400-year cycles while the total is strictly larger than one.
                if (!alu_flags.borrow && !alu_flags.zero) begin
                    n_total = alu_res;
                    n_year  = r_year + gdad_pkg::YEAR_W'(gdad_pkg::CYCLE_YEARS);
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (alu_flags.borrow || alu_flags.zero) begin
                    // The remainder fits in this month; finish once the output is free.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_end_day   = r_total[gdad_pkg::DAY_W-1:0];
                        n_end_month = r_m;
                        n_end_year  = r_year;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_total = alu_res;
                    if (r_m == gdad_pkg::MON_DEC) begin
                        n_m    = gdad_pkg::MON_JAN;
                        n_year = r_year + gdad_pkg::YEAR_W'(1);
                        if (r_yrem == gdad_pkg::YEAR_W'(gdad_pkg::CYCLE_YEARS - 1)) begin
                            n_yrem = '0;
                        end else begin
                            n_yrem = r_yrem + gdad_pkg::YEAR_W'(1);
                        end
                    end else begin
                        n_m = r_m + gdad_pkg::MON_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_total     <= n_total;
        r_year      <= n_year;
        r_yrem      <= n_yrem;
        r_m         <= n_m;
        r_mon       <= n_mon;
        r_day       <= n_day;
        r_step      <= n_step;
        r_end_day   <= n_end_day;
        r_end_month <= n_end_month;
        r_end_year  <= n_end_year;
    end

    // An accepted transaction always starts the year reduction.
    `GDAD_ASSERT_NEXT(a_accept_starts_work, i_in.valid && i_in.ready, r_state == S_MOD, "accepted transaction did not start the sequencer")
    // The month walk only visits real months.
    `GDAD_ASSERT_NOW(a_walk_month_range, r_state == S_WALK, r_m >= gdad_pkg::MON_JAN && r_m <= gdad_pkg::MON_DEC, "month walk left January to December")
    // After reduction the year remainder stays below one 400-year cycle.
    `GDAD_ASSERT_NOW(a_yrem_reduced, r_state == S_CYC || r_state == S_WALK, r_yrem < gdad_pkg::YEAR_W'(gdad_pkg::CYCLE_YEARS), "year remainder not reduced")
    // A result appears only at the end of a month walk.
    `GDAD_ASSERT_NOW(a_result_from_walk, $rose(o_out.valid), $past(r_state) == S_WALK, "result valid without a finished walk")

endmodule

`default_nettype wire

@@ design/gdad_alu.sv @@
// Shared add/subtract unit with borrow and zero flags.
`default_nettype none

module gdad_alu #(
    parameter int unsigned W = 22
) (
    input  wire logic [W-1:0]         i_a,
    input  wire logic [W-1:0]         i_b,
    input  wire logic                 i_sub,
    output logic [W-1:0]              o_res,
    output gdad_pkg::t_alu_flags      o_flags
);

    logic [W:0] sum;

    always_comb begin
        if (i_sub) begin
            sum = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            sum = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_res          = sum[W-1:0];
    assign o_flags.borrow = i_sub & sum[W];
    assign o_flags.zero   = (sum[W-1:0] == '0);

endmodule

`default_nettype wire

@@ bench/tb_gregorian_date_add_days_unit.sv @@
// Self-checking testbench for the Gregorian date adder: directed and random date queries.
`default_nettype none

module tb_gregorian_date_add_days_unit;

    localparam int unsigned DAYS_WIDTH = gdad_pkg::DAYS_WIDTH_DEF;

    // Half of the 12-unit clock period.
    localparam int unsigned HALF_PERIOD = 6;
    localparam int unsigned RESET_CYCLES = 10;

    // Idle time after the last result, to catch a stray extra transaction.
    localparam int unsigned SETTLE_CYCLES = 64;

    // Whole 400-year cycles are skipped, so the slowest transaction walks under 4800 months.
    // Even if every transaction took that long, the limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    // Length of the long output stall that makes the block back up and refuse input.
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    localparam int unsigned GAP_PERCENT = 12;
    localparam int unsigned RANDOM_DATES = 73;
    localparam int unsigned GAPLESS_DATES = 30;

    // One resulting date, as the output channel carries it.
    typedef struct packed {
        logic [gdad_pkg::DAY_W-1:0]  day;
        logic [gdad_pkg::MON_W-1:0]  month;
        logic [gdad_pkg::YEAR_W-1:0] year;
    } t_end_date;

    logic clk;
    logic rst_n;

    gdad_in_if #(.DAYS_WIDTH(DAYS_WIDTH)) in_if ();
    gdad_out_if out_if ();

    gregorian_date_add_days_unit #(
        .DAYS_WIDTH(DAYS_WIDTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Dates that the block still owes us, oldest first.
    t_end_date pending_dates[$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // When set, both the sender and the receiver insert random idle cycles.
    bit gaps_on = 1'b0;

    // Raised by a test to ask the receiver for one long stall; the receiver clears it.
    bit hold_off_req = 1'b0;

    // ------------------------------------------------------------------------------------
    // Calendar arithmetic of the expected results.
    // ------------------------------------------------------------------------------------

    // Leap years follow the 4/100/400 rule on the full year value, so year 0 is a leap year.
    function automatic bit is_leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % gdad_pkg::CENTURY != 0)) ||
               (yr % gdad_pkg::CYCLE_YEARS == 0);
    endfunction

    // Month codes outside January to December count as months of no length at all.
    function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
        if (mo < gdad_pkg::MON_JAN || mo > gdad_pkg::MON_DEC)
            return 0;
        if (mo == gdad_pkg::MON_FEB && is_leap_year(yr))
            return gdad_pkg::LEAP_FEB;
        return 32'(gdad_pkg::MONTH_LEN[mo - 1]);
    endfunction

    // The start date becomes an ordinal within its year, the day count is added, and the
    // ordinal is walked forward month by month from January 1 of the start year. Whole
    // 400-year cycles are skipped first since they always hold the same number of days.
    // The year is tracked without limit and only its low bits reach the output.
    function automatic t_end_date add_days_to_date(input logic [gdad_pkg::DAY_W-1:0]  d,
                                                   input logic [gdad_pkg::MON_W-1:0]  m,
                                                   input logic [gdad_pkg::YEAR_W-1:0] y,
                                                   input logic [DAYS_WIDTH-1:0]       n);
        longint unsigned ordinal;
        int unsigned     yr;
        int unsigned     mo;
        int unsigned     len;
        t_end_date       res;
        yr = 32'(y);
        ordinal = 64'(d);
        for (mo = 1; mo < 32'(m); mo++)
            ordinal += 64'(month_length(mo, yr));
        ordinal += 64'(n);
        while (ordinal > 64'(gdad_pkg::CYCLE_DAYS)) begin
            ordinal -= 64'(gdad_pkg::CYCLE_DAYS);
            yr += gdad_pkg::CYCLE_YEARS;
        end
        mo = 32'(gdad_pkg::MON_JAN);
        len = month_length(mo, yr);
        while (ordinal > 64'(len)) begin
            ordinal -= 64'(len);
            if (mo == 32'(gdad_pkg::MON_DEC)) begin
                mo = 32'(gdad_pkg::MON_JAN);
                yr++;
            end else begin
                mo++;
            end
            len = month_length(mo, yr);
        end
        res.day = gdad_pkg::DAY_W'(ordinal);
        res.month = gdad_pkg::MON_W'(mo);
        res.year = gdad_pkg::YEAR_W'(yr);
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Clock, reset and watchdog.
    // ------------------------------------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    // Every block input gets a known value at time zero; reset is released on a falling
    // edge and never asserted again.
    initial begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.start_day = '0;
        in_if.start_month = '0;
        in_if.start_year = '0;
        in_if.days_to_add = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // The run is cut short if the block hangs or drops a transaction.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------------------------

    initial begin : result_receiver
        int unsigned hold_left;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Checker: every result transaction is matched against the oldest pending date.
    // ------------------------------------------------------------------------------------

    initial begin : result_checker
        t_end_date want;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                if (pending_dates.size() == 0) begin
                    $error("result %0d-%0d-%0d arrived with no transaction pending",
                           out_if.end_year, out_if.end_month, out_if.end_day);
                    fail_count++;
                end else begin
                    want = pending_dates.pop_front();
                    if (out_if.end_day !== want.day) begin
                        $error("end_day: expected %0d, actual %0d", want.day, out_if.end_day);
                        fail_count++;
                    end
                    if (out_if.end_month !== want.month) begin
                        $error("end_month: expected %0d, actual %0d",
                               want.month, out_if.end_month);
                        fail_count++;
                    end
                    if (out_if.end_year !== want.year) begin
                        $error("end_year: expected %0d, actual %0d",
                               want.year, out_if.end_year);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Sender.
    // ------------------------------------------------------------------------------------

    // Offers one date query and returns on the rising edge that accepts it. Valid stays
    // high between back-to-back transactions; the next call changes it on a falling edge.
    task automatic send_date(input logic [gdad_pkg::DAY_W-1:0]  d,
                             input logic [gdad_pkg::MON_W-1:0]  m,
                             input logic [gdad_pkg::YEAR_W-1:0] y,
                             input logic [DAYS_WIDTH-1:0]       n);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.start_day <= d;
        in_if.start_month <= m;
        in_if.start_year <= y;
        in_if.days_to_add <= n;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        pending_dates.push_back(add_days_to_date(d, m, y, n));
    endtask

    // Mostly short spans, some of a few decades, and a few over the whole field so that
    // its top bits toggle without making the run slow.
    function automatic logic [DAYS_WIDTH-1:0] random_day_count();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return DAYS_WIDTH'($urandom_range(0, 400));
        if (pick < 92)
            return DAYS_WIDTH'($urandom_range(0, 20000));
        return DAYS_WIDTH'($urandom);
    endfunction

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // February in ordinary, leap, century and 400-year years, the turn of a year, and a
    // span of exactly one 400-year cycle.
    task automatic test_leap_rules();
        send_date(5'd28, gdad_pkg::MON_FEB, 14'd2024, 20'd1);
        send_date(5'd28, gdad_pkg::MON_FEB, 14'd2023, 20'd1);
        send_date(5'd28, gdad_pkg::MON_FEB, 14'd1900, 20'd1);
        send_date(5'd28, gdad_pkg::MON_FEB, 14'd2000, 20'd1);
        send_date(5'd31, gdad_pkg::MON_DEC, 14'd1999, 20'd1);
        send_date(5'd1, gdad_pkg::MON_JAN, 14'd1, DAYS_WIDTH'(gdad_pkg::CYCLE_DAYS));
    endtask

    // The smallest legal date with no days and with the largest day count, the largest legal
    // date with the largest day count, and a count with only its top bit set.
    task automatic test_field_extremes();
        send_date(5'd1, gdad_pkg::MON_JAN, 14'd1, '0);
        send_date(5'd31, gdad_pkg::MON_DEC, 14'd9999, '1);
        send_date(5'd1, gdad_pkg::MON_JAN, 14'd1, '1);
        send_date(5'd15, gdad_pkg::MON_W'(7), 14'd5000, DAYS_WIDTH'(1) << (DAYS_WIDTH - 1));
    endtask

    // Start dates outside the calendar: day zero, days past the end of a month, month
    // zero, months above December, year zero, years above 9999 and a wrapping year.
    task automatic test_odd_start_dates();
        send_date(5'd0, gdad_pkg::MON_JAN, 14'd2023, '0);
        send_date(5'd0, gdad_pkg::MON_W'(3), 14'd2023, '0);
        send_date(5'd31, gdad_pkg::MON_FEB, 14'd2023, '0);
        send_date(5'd31, gdad_pkg::MON_W'(4), 14'd2022, 20'd3);
        send_date(5'd5, gdad_pkg::MON_W'(0), 14'd2020, 20'd10);
        send_date(5'd1, gdad_pkg::MON_W'(13), 14'd2021, '0);
        send_date(5'd31, gdad_pkg::MON_W'(15), 14'd2021, 20'd100);
        send_date(5'd28, gdad_pkg::MON_FEB, 14'd0, 20'd1);
        send_date(5'd28, gdad_pkg::MON_FEB, 14'd12000, 20'd1);
        send_date(5'd31, gdad_pkg::MON_DEC, 14'd16383, 20'd1);
        send_date(5'd31, gdad_pkg::MON_DEC, 14'd16383, '1);
    endtask

    // The receiver stalls for a long stretch while short queries keep coming, so the
    // output register fills, the next walk stalls at its end and the input has to wait.
    task automatic test_output_backpressure();
        int unsigned k;
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        for (k = 0; k < 6; k++)
            send_date(gdad_pkg::DAY_W'($urandom_range(1, 28)),
                      gdad_pkg::MON_W'($urandom_range(1, 12)),
                      gdad_pkg::YEAR_W'($urandom_range(1, 9999)),
                      DAYS_WIDTH'($urandom_range(0, 40)));
    endtask

    // Mostly well-formed dates with random content, the rest raw noise on every field.
    // The first stretch runs without any idling on either side.
    task automatic test_random_dates();
        int unsigned                 k;
        logic [gdad_pkg::DAY_W-1:0]  d;
        logic [gdad_pkg::MON_W-1:0]  m;
        logic [gdad_pkg::YEAR_W-1:0] y;
        for (k = 0; k < RANDOM_DATES; k++) begin
            gaps_on = (k >= GAPLESS_DATES);
            if ($urandom_range(0, 99) < 85) begin
                m = gdad_pkg::MON_W'($urandom_range(gdad_pkg::MON_JAN, gdad_pkg::MON_DEC));
                y = gdad_pkg::YEAR_W'($urandom_range(1, 9999));
                d = gdad_pkg::DAY_W'($urandom_range(1, month_length(32'(m), 32'(y))));
            end else begin
                d = gdad_pkg::DAY_W'($urandom);
                m = gdad_pkg::MON_W'($urandom);
                y = gdad_pkg::YEAR_W'($urandom);
            end
            send_date(d, m, y, random_day_count());
        end
    endtask

    // Drops valid, waits for every owed result, then idles a little longer.
    task automatic drain_results();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        wait (rst_n === 1'b1);
        gaps_on = 1'b1;
        test_leap_rules();
        test_field_extremes();
        test_odd_start_dates();
        test_output_backpressure();
        test_random_dates();
        drain_results();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/gdad_pkg.sv
design/gdad_if.sv
design/gdad_alu.sv
design/gregorian_date_add_days_unit.sv
bench/tb_gregorian_date_add_days_unit.sv
